>>> src/key_matrix_autorepeat_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the key matrix auto-repeat unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_AUTOREPEAT_UNIT_ASSERT_SVH
`define KEY_MATRIX_AUTOREPEAT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define KMAR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("key matrix auto-repeat check failed");
// next-cycle implication
`define KMAR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key matrix auto-repeat check failed");
`else
`define KMAR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define KMAR_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> src/kmar_pkg.sv
// ----------------------------------------------------------------------------
// kmar_pkg
// Shared types and constants of the key matrix auto-repeat unit.
// ----------------------------------------------------------------------------
package kmar_pkg;

	localparam int KEY_SPACE_BITS = 56;
	localparam int NOW_BITS       = 32;
	localparam int KEY_IDX_BITS   = 6;
	localparam int COL_BITS       = 4;
	localparam int ROW_BITS       = 2;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 1;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_DELAY  = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_PERIOD = 1'd1;

	localparam logic [CFG_DATA_BITS-1:0] RESET_DELAY_MS  = 16'd420;
	localparam logic [CFG_DATA_BITS-1:0] RESET_PERIOD_MS = 16'd45;

	typedef struct packed {
		logic fn;
		logic shift;
		logic ctrl;
		logic opt;
		logic alt;
	} mods_t;

	// status of the key bit currently under the scan head
	typedef struct packed {
		logic                    plain;   // held and not a modifier
		logic                    fresh;   // plain and not held last scan
		logic                    at_rep;  // position of the current repeat key
		logic                    last;    // final key of the matrix
		logic [COL_BITS-1:0]     col;
		logic [ROW_BITS-1:0]     row;
		logic [KEY_IDX_BITS-1:0] idx;
	} scan_tap_t;

endpackage

>>> src/key_matrix_autorepeat_unit.sv
// ----------------------------------------------------------------------------
// key_matrix_autorepeat_unit
// Typematic press and repeat event generator for a scanned key matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one matrix scan as an item: the
//   pressed-key bitmap and the current millisecond time. Output channel
//   (out_valid/out_ready) gives one event item per fresh key press, in key
//   index order, then at most one auto-repeat event; last_event marks the
//   final event of a scan. A scan with no events gives no output item.
//   Configuration channel (cfg_valid/cfg_ready) writes the repeat delay
//   (index 0) and repeat period (index 1); write only while the unit is idle.
// Timing:
//   The scanner visits one key per cycle unless the scan is frozen by a stall,
//   over NK = min(rows * cols, 56) keys; each item then passes the arm, check
//   and flush states, plus the repeat state when a repeat event is sent, and
//   may wait on the output. The first event is loaded into the output register
//   as the second fresh key passes the scan head, or else in the flush or repeat state.
//   in_ready is high only between items.
// Reset: clears history, the repeat key and its deadline, and loads the
//   register defaults (delay 420 ms, period 45 ms).
// Stalls: one event waits in the output register and one more is held
//   pending; the scan freezes while both are full and another fresh key is met.
// ----------------------------------------------------------------------------
`include "key_matrix_autorepeat_unit_assert.svh"

module key_matrix_autorepeat_unit #(
	parameter int MATRIX_COLS = 14,
	parameter int MATRIX_ROWS = 4,
	parameter int TIME_BITS   = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [kmar_pkg::KEY_SPACE_BITS-1:0] pressed_keys,
	input  logic [kmar_pkg::NOW_BITS-1:0]       now_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [kmar_pkg::COL_BITS-1:0]       key_col,
	output logic [kmar_pkg::ROW_BITS-1:0]       key_row,
	output logic                                mod_fn,
	output logic                                mod_shft,
	output logic                                mod_ctl,
	output logic                                mod_opt,
	output logic                                mod_alt,
	output logic                                is_repeat,
	output logic                                last_event,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [kmar_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [kmar_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import kmar_pkg::*;

	// modifier positions; a column beyond the matrix is never held
	localparam bit HAS_SHIFT = MATRIX_COLS > 1;
	localparam bit HAS_ALT   = MATRIX_COLS > 2;
	localparam int IDX_FN    = 2 * MATRIX_COLS;
	localparam int IDX_SHIFT = HAS_SHIFT ? 2 * MATRIX_COLS + 1 : 0;
	localparam int IDX_CTRL  = 3 * MATRIX_COLS;
	localparam int IDX_OPT   = HAS_SHIFT ? 3 * MATRIX_COLS + 1 : 0;
	localparam int IDX_ALT   = HAS_ALT ? 3 * MATRIX_COLS + 2 : 0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_ARM,
		ST_CHECK,
		ST_FLUSH,
		ST_REPT
	} state_t;

	state_t state_q;

	logic [CFG_DATA_BITS-1:0] delay_ms;
	logic [CFG_DATA_BITS-1:0] period_ms;
	scan_tap_t                tap;

	// per-item context
	logic [TIME_BITS-1:0]    now_q;
	mods_t                   mods_q;
	logic                    any_fresh_q;
	logic                    held_old_q;
	logic                    fire_q;

	// one pending press event: last_event is only known once the next is found
	logic                    pend_valid_q;
	logic [COL_BITS-1:0]     pend_col_q;
	logic [ROW_BITS-1:0]     pend_row_q;
	logic [KEY_IDX_BITS-1:0] pend_idx_q;

	// repeat key state
	logic                    rep_valid_q;
	logic [KEY_IDX_BITS-1:0] rep_idx_q;
	logic [COL_BITS-1:0]     rep_col_q;
	logic [ROW_BITS-1:0]     rep_row_q;
	logic [TIME_BITS-1:0]    deadline_q;

	// output register
	logic                    out_valid_q;
	logic [COL_BITS-1:0]     out_col_q;
	logic [ROW_BITS-1:0]     out_row_q;
	mods_t                   out_mods_q;
	logic                    out_rep_q;
	logic                    out_last_q;

	logic                    out_free;
	logic                    scan_stall;
	logic                    scan_adv;
	logic                    scan_load;
	logic                    out_load;
	logic                    out_load_rep;
	logic [TIME_BITS-1:0]    since_deadline;
	logic                    passed;
	mods_t                   mods_in;

	kmar_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.delay_ms  (delay_ms),
		.period_ms (period_ms)
	);

	kmar_scan #(
		.MATRIX_COLS (MATRIX_COLS),
		.MATRIX_ROWS (MATRIX_ROWS)
	) u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (scan_load),
		.advance      (scan_adv),
		.pressed_keys (pressed_keys),
		.rep_idx      (rep_idx_q),
		.tap          (tap)
	);

	always_comb begin
		mods_in.fn    = pressed_keys[IDX_FN];
		mods_in.shift = HAS_SHIFT && pressed_keys[IDX_SHIFT];
		mods_in.ctrl  = pressed_keys[IDX_CTRL];
		mods_in.opt   = HAS_SHIFT && pressed_keys[IDX_OPT];
		mods_in.alt   = HAS_ALT && pressed_keys[IDX_ALT];
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign scan_load  = in_valid && in_ready;
	assign out_free   = !out_valid_q || out_ready;

	// freeze the scan when a fresh key would displace a pending event with nowhere to go
	assign scan_stall = tap.fresh && pend_valid_q && !out_free;
	assign scan_adv   = (state_q == ST_SCAN) && !scan_stall;

	assign out_load_rep = (state_q == ST_REPT) && out_free;
	assign out_load     = (scan_adv && tap.fresh && pend_valid_q) ||
	                      ((state_q == ST_FLUSH) && pend_valid_q && out_free) ||
	                      out_load_rep;

	// deadline has passed when the wrapped difference is non-negative
	assign since_deadline = now_q - deadline_q;
	assign passed         = !since_deadline[TIME_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			now_q        <= '0;
			mods_q       <= '0;
			any_fresh_q  <= 1'b0;
			held_old_q   <= 1'b0;
			fire_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_col_q   <= '0;
			pend_row_q   <= '0;
			pend_idx_q   <= '0;
			rep_valid_q  <= 1'b0;
			rep_idx_q    <= '0;
			rep_col_q    <= '0;
			rep_row_q    <= '0;
			deadline_q   <= '0;
			out_valid_q  <= 1'b0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			out_mods_q   <= '0;
			out_rep_q    <= 1'b0;
			out_last_q   <= 1'b0;
		end else begin
			// load a new item if due, otherwise drop the taken one
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_mods_q  <= mods_q;
				if (out_load_rep) begin
					out_col_q  <= rep_col_q;
					out_row_q  <= rep_row_q;
					out_rep_q  <= 1'b1;
					out_last_q <= 1'b1;
				end else begin
					out_col_q  <= pend_col_q;
					out_row_q  <= pend_row_q;
					out_rep_q  <= 1'b0;
					// a pending press is final only in the flush with no repeat behind it
					out_last_q <= (state_q == ST_FLUSH) && !fire_q;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						now_q        <= now_ms[TIME_BITS-1:0];
						mods_q       <= mods_in;
						any_fresh_q  <= 1'b0;
						held_old_q   <= 1'b0;
						pend_valid_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_adv) begin
						if (tap.at_rep) begin
							held_old_q <= tap.plain;
						end
						if (tap.fresh) begin
							pend_valid_q <= 1'b1;
							pend_col_q   <= tap.col;
							pend_row_q   <= tap.row;
							pend_idx_q   <= tap.idx;
							any_fresh_q  <= 1'b1;
						end
						if (tap.last) begin
							state_q <= ST_ARM;
						end
					end
				end
				ST_ARM: begin
					// the last fresh key takes over; otherwise keep the old key only if held
					if (any_fresh_q) begin
						rep_valid_q <= 1'b1;
						rep_idx_q   <= pend_idx_q;
						rep_col_q   <= pend_col_q;
						rep_row_q   <= pend_row_q;
						deadline_q  <= now_q + TIME_BITS'(delay_ms);
					end else if (!(rep_valid_q && held_old_q)) begin
						rep_valid_q <= 1'b0;
						rep_idx_q   <= '0;
						rep_col_q   <= '0;
						rep_row_q   <= '0;
					end
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					fire_q <= rep_valid_q && passed;
					if (rep_valid_q && passed) begin
						deadline_q <= now_q + TIME_BITS'(period_ms);
					end
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: begin
					if (pend_valid_q) begin
						if (out_free) begin
							pend_valid_q <= 1'b0;
							state_q      <= fire_q ? ST_REPT : ST_IDLE;
						end
					end else begin
						state_q <= fire_q ? ST_REPT : ST_IDLE;
					end
				end
				ST_REPT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign key_col    = out_col_q;
	assign key_row    = out_row_q;
	assign mod_fn     = out_mods_q.fn;
	assign mod_shft   = out_mods_q.shift;
	assign mod_ctl    = out_mods_q.ctrl;
	assign mod_opt    = out_mods_q.opt;
	assign mod_alt    = out_mods_q.alt;
	assign is_repeat  = out_rep_q;
	assign last_event = out_last_q;

	// no event is ever written over one that has not been taken
	`KMAR_ASSERT_IMP(a_load_free, clk, arst_n, out_load, out_free)
	// between items nothing is left pending
	`KMAR_ASSERT_IMP(a_idle_clean, clk, arst_n, in_ready, !pend_valid_q)
	// a repeat event is only sent after a passed deadline was found
	`KMAR_ASSERT_IMP(a_rept_fire, clk, arst_n, state_q == ST_REPT, fire_q && rep_valid_q)
	// the final key of the scan hands over to deadline arming
	`KMAR_ASSERT_NXT(a_scan_end, clk, arst_n, scan_adv && tap.last, state_q == ST_ARM)

endmodule

>>> src/kmar_cfg.sv
// ----------------------------------------------------------------------------
// kmar_cfg
// Repeat delay and period registers behind the configuration write channel.
// ----------------------------------------------------------------------------
module kmar_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [kmar_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [kmar_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic [kmar_pkg::CFG_DATA_BITS-1:0]   delay_ms,
	output logic [kmar_pkg::CFG_DATA_BITS-1:0]   period_ms
);
	import kmar_pkg::*;

	logic [CFG_DATA_BITS-1:0] delay_q;
	logic [CFG_DATA_BITS-1:0] period_q;

	assign cfg_ready = 1'b1;
	assign delay_ms  = delay_q;
	assign period_ms = period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= RESET_DELAY_MS;
			period_q <= RESET_PERIOD_MS;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_REPEAT_DELAY:  delay_q  <= cfg_data;
				CFG_REPEAT_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

>>> src/kmar_scan.sv
// ----------------------------------------------------------------------------
// kmar_scan
// Bit-serial matrix scanner: shifts the scan and the previous scan one key
// per cycle on advance, tracks column and row, and flags fresh plain keys.
// ----------------------------------------------------------------------------
module kmar_scan #(
	parameter int MATRIX_COLS = 14,
	parameter int MATRIX_ROWS = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                advance,
	input  logic [kmar_pkg::KEY_SPACE_BITS-1:0] pressed_keys,
	input  logic [kmar_pkg::KEY_IDX_BITS-1:0]   rep_idx,
	output kmar_pkg::scan_tap_t                 tap
);
	import kmar_pkg::*;

	localparam int NK_RAW = MATRIX_ROWS * MATRIX_COLS;
	localparam int NK     = (NK_RAW > KEY_SPACE_BITS) ? KEY_SPACE_BITS : NK_RAW;
	localparam logic [KEY_IDX_BITS-1:0] LAST_IDX = KEY_IDX_BITS'(NK - 1);
	localparam logic [COL_BITS-1:0]     LAST_COL = COL_BITS'(MATRIX_COLS - 1);
	localparam logic [ROW_BITS-1:0]     ROW_MOD_A = 2'd2;
	localparam logic [ROW_BITS-1:0]     ROW_MOD_B = 2'd3;

	logic [NK-1:0]           keys_q;
	logic [NK-1:0]           prev_q;
	logic [KEY_IDX_BITS-1:0] idx_q;
	logic [COL_BITS-1:0]     col_q;
	logic [ROW_BITS-1:0]     row_q;
	logic                    is_mod;
	logic                    plain;

	// fn/shift on row 2, ctrl/opt/alt on row 3
	assign is_mod = ((row_q == ROW_MOD_A) && (col_q <= 4'd1)) ||
	                ((row_q == ROW_MOD_B) && (col_q <= 4'd2));
	assign plain  = keys_q[0] & ~is_mod;

	always_comb begin
		tap.plain  = plain;
		tap.fresh  = plain & ~prev_q[0];
		tap.at_rep = (idx_q == rep_idx);
		tap.last   = (idx_q == LAST_IDX);
		tap.col    = col_q;
		tap.row    = row_q;
		tap.idx    = idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			prev_q <= '0;
			idx_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (load) begin
			keys_q <= pressed_keys[NK-1:0];
			idx_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (advance) begin
			// previous scan is rotated so it lines up again after a full pass
			keys_q <= keys_q >> 1;
			prev_q <= {plain, prev_q[NK-1:1]};
			idx_q  <= idx_q + 1'b1;
			if (col_q == LAST_COL) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

>>> bench/key_matrix_autorepeat_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// key_matrix_autorepeat_unit_tb
// Self-checking bench for the typematic press and repeat event generator.
// Matrix scans and register writes are queued by a plan, fed to the unit by a
// clocked driver and predicted on acceptance. A posedge monitor compares every
// event item with the oldest prediction. Random idling on both channels.
// ----------------------------------------------------------------------------
module key_matrix_autorepeat_unit_tb;
	import kmar_pkg::*;

	localparam int N_COLS = 14;
	localparam int N_KEYS = 56;

	// modifier positions, bit row*cols+col
	localparam int FN_BIT    = 2 * N_COLS + 0;
	localparam int SHIFT_BIT = 2 * N_COLS + 1;
	localparam int CTRL_BIT  = 3 * N_COLS + 0;
	localparam int OPT_BIT   = 3 * N_COLS + 1;
	localparam int ALT_BIT   = 3 * N_COLS + 2;
	localparam logic [KEY_SPACE_BITS-1:0] MOD_KEYS =
		(56'd1 << FN_BIT) | (56'd1 << SHIFT_BIT) | (56'd1 << CTRL_BIT) |
		(56'd1 << OPT_BIT) | (56'd1 << ALT_BIT);

	// an item with no events may still be scanning when the last event has gone
	localparam int SETTLE_CYCLES  = 80;
	localparam int TAIL_CYCLES    = 100;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 6;
	localparam int PHASE_ITEMS    = 55;

	typedef enum logic [1:0] {OP_SCAN, OP_CFG, OP_DRAIN, OP_IDLING} op_kind_t;

	typedef struct {
		op_kind_t                  kind;
		logic [KEY_SPACE_BITS-1:0] keys;
		logic [NOW_BITS-1:0]       now;
		logic [CFG_INDEX_BITS-1:0] reg_idx;
		logic [CFG_DATA_BITS-1:0]  reg_val;
		int unsigned               src_pct;
		int unsigned               sink_pct;
	} bench_op_t;

	typedef struct packed {
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
		mods_t               mods;
		logic                rpt;
		logic                last;
	} key_event_t;

	// ------------------------------------------------------------------------
	// Clock, reset and ports
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic [KEY_SPACE_BITS-1:0] pressed_keys = '0;
	logic [NOW_BITS-1:0]       now_ms       = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic [COL_BITS-1:0]       key_col;
	logic [ROW_BITS-1:0]       key_row;
	logic                      mod_fn, mod_shft, mod_ctl, mod_opt, mod_alt;
	logic                      is_repeat;
	logic                      last_event;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

	always #2 clk = ~clk;

	key_matrix_autorepeat_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.pressed_keys(pressed_keys),
		.now_ms     (now_ms),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.key_col    (key_col),
		.key_row    (key_row),
		.mod_fn     (mod_fn),
		.mod_shft   (mod_shft),
		.mod_ctl    (mod_ctl),
		.mod_opt    (mod_opt),
		.mod_alt    (mod_alt),
		.is_repeat  (is_repeat),
		.last_event (last_event),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ------------------------------------------------------------------------
	// Bench state
	// ------------------------------------------------------------------------
	bench_op_t  bench_ops[$];       // scans, writes and pauses still to drive
	key_event_t pending_events[$];  // events predicted but not yet seen

	logic        in_fire       = 1'b0;  // item taken at the last rising edge
	logic        cfg_fire      = 1'b0;  // write taken at the last rising edge
	int          hold_cnt      = 0;
	int          settle_cnt    = 0;
	logic        draining      = 1'b0;
	int unsigned src_idle_pct  = 0;
	int unsigned sink_idle_pct = 0;
	int          stall_cnt     = 0;
	int          idle_cycles   = 0;
	int          mismatches    = 0;

	// plan-side view of the settings, used only to shape time steps
	logic [KEY_SPACE_BITS-1:0] plan_keys   = '0;
	logic [NOW_BITS-1:0]       plan_now    = '0;
	int                        plan_delay  = RESET_DELAY_MS;
	int                        plan_period = RESET_PERIOD_MS;

	// ------------------------------------------------------------------------
	// Typematic predictor: own copy of history, repeat key and registers
	// ------------------------------------------------------------------------
	logic [KEY_SPACE_BITS-1:0] held_plain = '0;
	logic                      rep_armed  = 1'b0;
	logic [KEY_IDX_BITS-1:0]   rep_key    = '0;
	logic [NOW_BITS-1:0]       rep_due    = '0;
	logic [CFG_DATA_BITS-1:0]  delay_ms   = RESET_DELAY_MS;
	logic [CFG_DATA_BITS-1:0]  period_ms  = RESET_PERIOD_MS;

	function automatic key_event_t make_event(input int idx, input mods_t held_mods,
		input logic rpt);
		key_event_t ev;
		ev.col  = COL_BITS'(idx % N_COLS);
		ev.row  = ROW_BITS'(idx / N_COLS);
		ev.mods = held_mods;
		ev.rpt  = rpt;
		ev.last = 1'b0;
		return ev;
	endfunction

	function automatic void predict_scan_events(input logic [KEY_SPACE_BITS-1:0] keys,
		input logic [NOW_BITS-1:0] now);
		logic [KEY_SPACE_BITS-1:0] plain;
		logic [KEY_SPACE_BITS-1:0] fresh;
		logic [NOW_BITS-1:0]       lag;
		mods_t                     m;
		key_event_t                burst[$];
		m.fn    = keys[FN_BIT];
		m.shift = keys[SHIFT_BIT];
		m.ctrl  = keys[CTRL_BIT];
		m.opt   = keys[OPT_BIT];
		m.alt   = keys[ALT_BIT];
		plain = keys & ~MOD_KEYS;
		fresh = plain & ~held_plain;
		// presses in index order; the last one takes over the repeat
		for (int i = 0; i < N_KEYS; i++) begin
			if (fresh[i]) begin
				burst.insert(burst.size(), make_event(i, m, 1'b0));
				rep_armed = 1'b1;
				rep_key   = KEY_IDX_BITS'(i);
				rep_due   = now + NOW_BITS'(delay_ms);
			end
		end
		// deadline passed when the wrapped difference is non-negative
		lag = now - rep_due;
		if (!rep_armed || !plain[rep_key]) begin
			rep_armed = 1'b0;
			rep_key   = '0;
		end else if (!lag[NOW_BITS-1]) begin
			burst.insert(burst.size(), make_event(int'(rep_key), m, 1'b1));
			rep_due = now + NOW_BITS'(period_ms);
		end
		held_plain = plain;
		if (burst.size() != 0)
			burst[burst.size()-1].last = 1'b1;
		foreach (burst[k])
			pending_events.insert(pending_events.size(), burst[k]);
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// ------------------------------------------------------------------------
	// Plan builders
	// ------------------------------------------------------------------------
	task automatic add_scan(input logic [KEY_SPACE_BITS-1:0] keys,
		input logic [NOW_BITS-1:0] now);
		bench_op_t op;
		op.kind = OP_SCAN;
		op.keys = keys;
		op.now  = now;
		bench_ops.insert(bench_ops.size(), op);
	endtask

	// write only once the unit has gone quiet
	task automatic add_cfg(input logic [CFG_INDEX_BITS-1:0] idx, input int value);
		bench_op_t op;
		op.kind = OP_DRAIN;
		bench_ops.insert(bench_ops.size(), op);
		op.kind    = OP_CFG;
		op.reg_idx = idx;
		op.reg_val = CFG_DATA_BITS'(value);
		bench_ops.insert(bench_ops.size(), op);
		if (idx == CFG_REPEAT_DELAY)
			plan_delay = value;
		else
			plan_period = value;
	endtask

	task automatic add_idling(input int unsigned src_pct, input int unsigned sink_pct);
		bench_op_t op;
		op.kind     = OP_IDLING;
		op.src_pct  = src_pct;
		op.sink_pct = sink_pct;
		bench_ops.insert(bench_ops.size(), op);
	endtask

	// mostly held keys with a few presses and releases, time stepping so that
	// deadlines are met and missed; now and then a noise scan or a full clear
	task automatic add_typing_session(input int n_items);
		int                  b;
		int                  pick;
		logic [63:0]         noise;
		logic [NOW_BITS-1:0] step;
		for (int n = 0; n < n_items; n++) begin
			pick  = $urandom_range(0, 19);
			noise = {$urandom, $urandom};
			if (pick < 9) begin
				repeat ($urandom_range(1, 3)) begin
					b = $urandom_range(0, N_KEYS - 1);
					plan_keys[b] = ~plan_keys[b];
				end
			end else if (pick < 16) begin
				// hold the current keys and let the repeat run
			end else if (pick < 18) begin
				plan_keys = noise[KEY_SPACE_BITS-1:0];
			end else if (pick == 18) begin
				plan_keys = '0;
			end else begin
				plan_keys = plan_keys | noise[KEY_SPACE_BITS-1:0];
			end
			case ($urandom_range(0, 7))
				0, 1, 2: step = $urandom_range(0, 3);
				3, 4:    step = $urandom_range(0, 2 * plan_period + 1);
				5, 6:    step = $urandom_range(0, plan_delay + plan_period + 1);
				default: step = $urandom;
			endcase
			plan_now = plan_now + step;
			add_scan(plan_keys, plan_now);
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: one item or write in flight, gaps after acceptance, pauses
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		bench_op_t op;
		logic      drive_scan;
		logic      drive_cfg;
		if (arst_n) begin
			drive_scan = in_valid && !in_fire;
			drive_cfg  = cfg_valid && !cfg_fire;
			// now and then insert a gap after an accepted item or write
			if ((in_valid && in_fire) || (cfg_valid && cfg_fire)) begin
				if ($urandom_range(0, 99) < src_idle_pct)
					hold_cnt = $urandom_range(1, 14);
			end
			if (!drive_scan && !drive_cfg) begin
				if (hold_cnt != 0) begin
					hold_cnt--;
				end else if (draining) begin
					// hold until every predicted event is out, then let it settle
					if (pending_events.size() == 0) begin
						if (settle_cnt != 0)
							settle_cnt--;
						else
							draining = 1'b0;
					end
				end else if (bench_ops.size() != 0) begin
					op = bench_ops.pop_front();
					case (op.kind)
						OP_SCAN: begin
							drive_scan   = 1'b1;
							pressed_keys <= op.keys;
							now_ms       <= op.now;
						end
						OP_CFG: begin
							drive_cfg = 1'b1;
							cfg_index <= op.reg_idx;
							cfg_data  <= op.reg_val;
						end
						OP_DRAIN: begin
							draining   = 1'b1;
							settle_cnt = SETTLE_CYCLES;
						end
						default: begin
							src_idle_pct  = op.src_pct;
							sink_idle_pct <= op.sink_pct;
						end
					endcase
				end
			end
			in_valid  <= drive_scan;
			cfg_valid <= drive_cfg;
		end
	end

	// Event sink: stall in bursts
	always @(negedge clk) begin
		if (stall_cnt != 0) begin
			out_ready <= 1'b0;
			stall_cnt <= stall_cnt - 1;
		end else if ($urandom_range(0, 99) < sink_idle_pct) begin
			out_ready <= 1'b0;
			stall_cnt <= $urandom_range(0, 13);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: predict on acceptance, compare events, watch for a hang
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		key_event_t want;
		logic       moved;
		if (arst_n) begin
			moved    = 1'b0;
			in_fire  <= in_valid && in_ready;
			cfg_fire <= cfg_valid && cfg_ready;
			if (in_valid && in_ready) begin
				predict_scan_events(pressed_keys, now_ms);
				moved = 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_REPEAT_DELAY:  delay_ms  = cfg_data;
					CFG_REPEAT_PERIOD: period_ms = cfg_data;
					default: ;
				endcase
				moved = 1'b1;
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (pending_events.size() == 0) begin
					$error("unexpected event: col %0d row %0d repeat %0d",
						key_col, key_row, is_repeat);
					mismatches++;
				end else begin
					want = pending_events.pop_front();
					check_field("key_col", want.col, key_col);
					check_field("key_row", want.row, key_row);
					check_field("mod_fn", want.mods.fn, mod_fn);
					check_field("mod_shft", want.mods.shift, mod_shft);
					check_field("mod_ctl", want.mods.ctrl, mod_ctl);
					check_field("mod_opt", want.mods.opt, mod_opt);
					check_field("mod_alt", want.mods.alt, mod_alt);
					check_field("is_repeat", want.rpt, is_repeat);
					check_field("last_event", want.last, last_event);
				end
			end
			if (moved) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Plan and end of run
	// ------------------------------------------------------------------------
	initial begin
		int d;
		int q;

		// directed part, register defaults: delay 420, period 45
		add_idling(20, 15);
		add_scan('0, 32'd0);
		add_scan(56'd1, 32'd100);                  // press, due at 520
		add_scan(56'd1, 32'd519);                  // one short of the deadline
		add_scan(56'd1, 32'd520);                  // first repeat
		add_scan(56'd1 | MOD_KEYS, 32'd600);       // repeat with every modifier
		add_scan('1, 32'd601);                     // every other key pressed at once
		add_scan('0, 32'd602);                     // repeat key released
		add_scan(56'd1 << 55, 32'hFFFF_FF00);      // deadline wraps past zero
		add_scan(56'd1 << 55, 32'h0000_00A3);
		add_scan(56'd1 << 55, 32'h0000_00A4);
		add_scan((56'd1 << 55) | (56'd1 << 13) | (56'd1 << 27), 32'h0000_00B0);
		add_scan((56'd1 << 55) | (56'd1 << 13), 32'h0000_1000);
		add_scan(MOD_KEYS, 32'h0000_1001);         // modifiers alone give nothing
		add_scan(56'hAA_AAAA_AAAA_AAAA, 32'h0000_2000);
		add_scan(56'h55_5555_5555_5555, 32'h0000_2001);

		// zero delay: press and repeat in the same scan, most events per item
		add_cfg(CFG_REPEAT_DELAY, 0);
		add_cfg(CFG_REPEAT_PERIOD, 1);
		add_scan('0, 32'h0000_3000);
		add_scan('1, 32'h0000_3001);
		add_scan('0, 32'd0);
		add_scan(56'd1 << 5, 32'd10);
		add_scan(56'd1 << 5, 32'd10);
		add_scan(56'd1 << 5, 32'd11);

		// zero period: repeat on every scan while held
		add_cfg(CFG_REPEAT_PERIOD, 0);
		add_scan(56'd1 << 5, 32'd12);
		add_scan(56'd1 << 5, 32'd12);

		// largest settings, deadline across the sign boundary
		add_cfg(CFG_REPEAT_DELAY, 65535);
		add_cfg(CFG_REPEAT_PERIOD, 65535);
		add_scan('0, 32'h7FFF_0000);
		add_scan(56'd1 << 40, 32'h7FFF_0000);
		add_scan(56'd1 << 40, 32'h7FFF_FFFE);
		add_scan(56'd1 << 40, 32'h8000_0000);

		// random typing under several settings; no idling in the last phase
		plan_keys = '0;
		plan_now  = 32'h8000_0000;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin d = $urandom_range(0, 60);    q = $urandom_range(1, 20);    end
				1: begin d = 0;                        q = 1;                        end
				2: begin d = 65535;                    q = 65535;                    end
				3: begin d = $urandom_range(0, 65535); q = $urandom_range(1, 65535); end
				4: begin d = RESET_DELAY_MS;           q = RESET_PERIOD_MS;          end
				default: begin d = $urandom_range(0, 500); q = $urandom_range(1, 100); end
			endcase
			add_cfg(CFG_REPEAT_DELAY, d);
			add_cfg(CFG_REPEAT_PERIOD, q);
			if (p % 2 == 1)
				add_idling(0, 0);
			else
				add_idling($urandom_range(10, 50), $urandom_range(5, 30));
			add_typing_session(PHASE_ITEMS);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// wait for the plan to run out and every event to arrive
		while (bench_ops.size() != 0 || in_valid || cfg_valid || draining ||
		       hold_cnt != 0 || pending_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
